// ===== rtl/sfd_pkg.sv =====
// Package for the sync-framed deframer: phase codes, result kinds, result struct,
// reset values and the CRC-16/MODBUS byte update. No dependencies.
`default_nettype none

package sfd_pkg;

  localparam int BYTE_W   = 8;
  localparam int CRC_W    = 16;
  localparam int KIND_W   = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [CRC_W-1:0]  CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0]  CRC_POLY = 16'hA001;
  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'h6C;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'hAA;

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_CRC_OK   = 2'd1,
    KIND_CRC_BAD  = 2'd2
  } kind_t;

  typedef enum logic [7:0] {
    PH_HUNT     = 8'b0000_0001,
    PH_SYNC2    = 8'b0000_0010,
    PH_TYPE_HI  = 8'b0000_0100,
    PH_TYPE_LO  = 8'b0000_1000,
    PH_LENGTH   = 8'b0001_0000,
    PH_PAYLOAD  = 8'b0010_0000,
    PH_CHECK_HI = 8'b0100_0000,
    PH_CHECK_LO = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    kind_t              kind;
    logic [BYTE_W-1:0]  data_byte;
    logic [BYTE_W-1:0]  byte_index;
    logic [CRC_W-1:0]   frame_type;
    logic [BYTE_W-1:0]  frame_length;
    logic [CRC_W-1:0]   received_check;
    logic [CRC_W-1:0]   computed_check;
  } result_t;

  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sfd_parser.sv =====
// Frame parser: phase state machine, header capture, running CRC and result forming.
// Depends on sfd_pkg.
`default_nettype none

module sfd_parser (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      step,
  input  wire logic [sfd_pkg::BYTE_W-1:0] byte_i,
  input  wire logic [sfd_pkg::BYTE_W-1:0] sync_first,
  input  wire logic [sfd_pkg::BYTE_W-1:0] sync_second,
  output logic                           res_valid,
  output sfd_pkg::result_t               res
);

  sfd_pkg::phase_t              phase_r, phase_nxt;
  logic [sfd_pkg::CRC_W-1:0]    type_r, type_nxt;
  logic [sfd_pkg::BYTE_W-1:0]   len_r, len_nxt;
  logic [sfd_pkg::BYTE_W-1:0]   cnt_r, cnt_nxt;
  logic [sfd_pkg::CRC_W-1:0]    crc_r, crc_nxt;
  logic [sfd_pkg::BYTE_W-1:0]   chk_hi_r, chk_hi_nxt;
  logic [sfd_pkg::CRC_W-1:0]    crc_upd;
  logic [sfd_pkg::CRC_W-1:0]    crc_first;
  logic [sfd_pkg::CRC_W-1:0]    rx_check;
  logic [sfd_pkg::BYTE_W-1:0]   cnt_inc;

  assign crc_upd   = sfd_pkg::crc_byte(crc_r, byte_i);
  assign crc_first = sfd_pkg::crc_byte(sfd_pkg::CRC_INIT, byte_i);
  assign rx_check  = {chk_hi_r, byte_i};
  assign cnt_inc   = cnt_r + 8'd1;

  assign res_valid = (phase_r == sfd_pkg::PH_PAYLOAD) || (phase_r == sfd_pkg::PH_CHECK_LO);

  always_comb begin
    res = '0;
    res.frame_type   = type_r;
    res.frame_length = len_r;
    if (phase_r == sfd_pkg::PH_PAYLOAD) begin
      res.kind       = sfd_pkg::KIND_PAYLOAD;
      res.data_byte  = byte_i;
      res.byte_index = cnt_r;
    end else begin
      res.kind           = (rx_check == crc_r) ? sfd_pkg::KIND_CRC_OK : sfd_pkg::KIND_CRC_BAD;
      res.received_check = rx_check;
      res.computed_check = crc_r;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    type_nxt   = type_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    crc_nxt    = crc_r;
    chk_hi_nxt = chk_hi_r;
    if (step) begin
      case (phase_r)
        sfd_pkg::PH_HUNT: begin
          if (byte_i == sync_first) begin
            crc_nxt   = crc_first;
            phase_nxt = sfd_pkg::PH_SYNC2;
          end
        end
        sfd_pkg::PH_SYNC2: begin
          if (byte_i == sync_second) begin
            crc_nxt   = crc_upd;
            phase_nxt = sfd_pkg::PH_TYPE_HI;
          end else begin
            phase_nxt = sfd_pkg::PH_HUNT;
          end
        end
        sfd_pkg::PH_TYPE_HI: begin
          type_nxt  = {byte_i, 8'h00};
          crc_nxt   = crc_upd;
          phase_nxt = sfd_pkg::PH_TYPE_LO;
        end
        sfd_pkg::PH_TYPE_LO: begin
          type_nxt  = {type_r[15:8], byte_i};
          crc_nxt   = crc_upd;
          phase_nxt = sfd_pkg::PH_LENGTH;
        end
        sfd_pkg::PH_LENGTH: begin
          len_nxt   = byte_i;
          cnt_nxt   = '0;
          crc_nxt   = crc_upd;
          phase_nxt = (byte_i != '0) ? sfd_pkg::PH_PAYLOAD : sfd_pkg::PH_CHECK_HI;
        end
        sfd_pkg::PH_PAYLOAD: begin
          crc_nxt = crc_upd;
          cnt_nxt = cnt_inc;
          if (cnt_inc == len_r) begin
            phase_nxt = sfd_pkg::PH_CHECK_HI;
          end
        end
        sfd_pkg::PH_CHECK_HI: begin
          chk_hi_nxt = byte_i;
          phase_nxt  = sfd_pkg::PH_CHECK_LO;
        end
        default: begin
          phase_nxt = sfd_pkg::PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= sfd_pkg::PH_HUNT;
      type_r   <= '0;
      len_r    <= '0;
      cnt_r    <= '0;
      crc_r    <= sfd_pkg::CRC_INIT;
      chk_hi_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      type_r   <= type_nxt;
      len_r    <= len_nxt;
      cnt_r    <= cnt_nxt;
      crc_r    <= crc_nxt;
      chk_hi_r <= chk_hi_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cnt_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == sfd_pkg::PH_PAYLOAD |-> cnt_r < len_r)
    else $error("payload count reached length while still in payload");

  a_last_payload: assert property (@(posedge clk) disable iff (!rst_n)
    step && phase_r == sfd_pkg::PH_PAYLOAD && cnt_inc == len_r
    |=> phase_r == sfd_pkg::PH_CHECK_HI)
    else $error("last payload item did not move to check phase");

  a_crc_seed: assert property (@(posedge clk) disable iff (!rst_n)
    step && phase_r == sfd_pkg::PH_HUNT && byte_i == sync_first
    |=> crc_r == sfd_pkg::crc_byte(sfd_pkg::CRC_INIT, $past(byte_i)))
    else $error("CRC not seeded from first sync byte");
`endif

endmodule

`default_nettype wire

// ===== rtl/sync_frame_deframer_crc16.sv =====
// Top level of the sync-framed deframer with CRC-16/MODBUS check.
// Depends on sfd_pkg and sfd_parser.
//
// Takes one received byte per item and accepts a new item every cycle while the
// result side keeps up. An item waits in an input register, where the parser updates
// its phase and running CRC with a combinational, fully unrolled byte-wide CRC step;
// any result is loaded into the output register when the item advances, so a result
// passes through the input register and then the output register. A stalled output
// only holds the input side when the waiting item itself produces a result. Sync
// bytes are programmable through the cfg_ port (index 0 first, index 1 second).
`default_nettype none

module sync_frame_deframer_crc16 (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [sfd_pkg::BYTE_W-1:0]   in_rx_byte,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [sfd_pkg::KIND_W-1:0]        out_kind,
  output logic [sfd_pkg::BYTE_W-1:0]        out_data_byte,
  output logic [sfd_pkg::BYTE_W-1:0]        out_byte_index,
  output logic [sfd_pkg::CRC_W-1:0]         out_frame_type,
  output logic [sfd_pkg::BYTE_W-1:0]        out_frame_length,
  output logic [sfd_pkg::CRC_W-1:0]         out_received_check,
  output logic [sfd_pkg::CRC_W-1:0]         out_computed_check,
  input  wire logic                         cfg_we,
  input  wire logic [sfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sfd_pkg::BYTE_W-1:0]   cfg_wdata
);

  logic [sfd_pkg::BYTE_W-1:0] sync_first_r, sync_second_r;
  logic                       in_vld_r, in_vld_nxt;
  logic [sfd_pkg::BYTE_W-1:0] in_byte_r;
  logic                       out_vld_r, out_vld_nxt;
  sfd_pkg::result_t           out_res_r;
  logic                       adv;
  logic                       res_valid;
  sfd_pkg::result_t           res;

  sfd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (adv),
    .byte_i      (in_byte_r),
    .sync_first  (sync_first_r),
    .sync_second (sync_second_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  assign adv      = in_vld_r && (!res_valid || !out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_valid && in_ready) begin
      in_vld_nxt = 1'b1;
    end else if (adv) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (adv && res_valid) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= sfd_pkg::SYNC_FIRST_RST;
      sync_second_r <= sfd_pkg::SYNC_SECOND_RST;
      in_vld_r      <= 1'b0;
      out_vld_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sfd_pkg::CFG_SYNC_FIRST:  sync_first_r  <= cfg_wdata;
          sfd_pkg::CFG_SYNC_SECOND: sync_second_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
    if (adv && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_kind           = out_res_r.kind;
  assign out_data_byte      = out_res_r.data_byte;
  assign out_byte_index     = out_res_r.byte_index;
  assign out_frame_type     = out_res_r.frame_type;
  assign out_frame_length   = out_res_r.frame_length;
  assign out_received_check = out_res_r.received_check;
  assign out_computed_check = out_res_r.computed_check;

endmodule

`default_nettype wire

// ===== sim/tb_sync_frame_deframer_crc16.sv =====
// Self-checking bench for sync_frame_deframer_crc16: framed byte streams with random
// handshake gaps, sync register changes and a scoreboard that tracks the frame parser.
// Depends on sfd_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

module tb_sync_frame_deframer_crc16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [sfd_pkg::BYTE_W-1:0] in_rx_byte = '0;
  logic out_ready = 1'b0;
  logic cfg_we = 1'b0;
  logic [sfd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [sfd_pkg::BYTE_W-1:0] cfg_wdata = '0;

  wire in_ready;
  wire out_valid;
  wire [sfd_pkg::KIND_W-1:0] out_kind;
  wire [sfd_pkg::BYTE_W-1:0] out_data_byte;
  wire [sfd_pkg::BYTE_W-1:0] out_byte_index;
  wire [sfd_pkg::CRC_W-1:0] out_frame_type;
  wire [sfd_pkg::BYTE_W-1:0] out_frame_length;
  wire [sfd_pkg::CRC_W-1:0] out_received_check;
  wire [sfd_pkg::CRC_W-1:0] out_computed_check;

  class frame_scoreboard;
    logic [sfd_pkg::BYTE_W-1:0] sync_first;
    logic [sfd_pkg::BYTE_W-1:0] sync_second;
    sfd_pkg::phase_t state;
    logic [sfd_pkg::CRC_W-1:0] type_word;
    logic [sfd_pkg::BYTE_W-1:0] len_byte;
    logic [sfd_pkg::BYTE_W-1:0] count;
    logic [sfd_pkg::BYTE_W-1:0] check_hi;
    logic [sfd_pkg::CRC_W-1:0] crc;
    sfd_pkg::result_t expected_q[$];
    int errors;

    function new();
      sync_first = sfd_pkg::SYNC_FIRST_RST;
      sync_second = sfd_pkg::SYNC_SECOND_RST;
      state = sfd_pkg::PH_HUNT;
      type_word = '0;
      len_byte = '0;
      count = '0;
      check_hi = '0;
      crc = sfd_pkg::CRC_INIT;
      errors = 0;
    endfunction

    static function logic [sfd_pkg::CRC_W-1:0] crc_step(logic [sfd_pkg::CRC_W-1:0] c,
                                                        logic [sfd_pkg::BYTE_W-1:0] b);
      logic fb;
      for (int i = 0; i < sfd_pkg::BYTE_W; i++) begin
        fb = c[0] ^ b[i];
        c = c >> 1;
        if (fb) begin
          c = c ^ sfd_pkg::CRC_POLY;
        end
      end
      return c;
    endfunction

    function void write_reg(logic [sfd_pkg::CFG_IDX_W-1:0] idx, logic [sfd_pkg::BYTE_W-1:0] v);
      if (idx == sfd_pkg::CFG_SYNC_FIRST) begin
        sync_first = v;
      end else if (idx == sfd_pkg::CFG_SYNC_SECOND) begin
        sync_second = v;
      end
    endfunction

    function void note_input(logic [sfd_pkg::BYTE_W-1:0] b);
      sfd_pkg::result_t r;
      logic [sfd_pkg::CRC_W-1:0] rx;
      r = '0;
      case (state)
        sfd_pkg::PH_HUNT: begin
          if (b == sync_first) begin
            crc = crc_step(sfd_pkg::CRC_INIT, b);
            state = sfd_pkg::PH_SYNC2;
          end
        end
        sfd_pkg::PH_SYNC2: begin
          if (b == sync_second) begin
            crc = crc_step(crc, b);
            state = sfd_pkg::PH_TYPE_HI;
          end else begin
            state = sfd_pkg::PH_HUNT;
          end
        end
        sfd_pkg::PH_TYPE_HI: begin
          type_word = {b, 8'h00};
          crc = crc_step(crc, b);
          state = sfd_pkg::PH_TYPE_LO;
        end
        sfd_pkg::PH_TYPE_LO: begin
          type_word[7:0] = b;
          crc = crc_step(crc, b);
          state = sfd_pkg::PH_LENGTH;
        end
        sfd_pkg::PH_LENGTH: begin
          len_byte = b;
          count = '0;
          crc = crc_step(crc, b);
          state = (b != 0) ? sfd_pkg::PH_PAYLOAD : sfd_pkg::PH_CHECK_HI;
        end
        sfd_pkg::PH_PAYLOAD: begin
          crc = crc_step(crc, b);
          r.kind = sfd_pkg::KIND_PAYLOAD;
          r.data_byte = b;
          r.byte_index = count;
          r.frame_type = type_word;
          r.frame_length = len_byte;
          expected_q.push_back(r);
          count = count + 8'd1;
          if (count == len_byte) begin
            state = sfd_pkg::PH_CHECK_HI;
          end
        end
        sfd_pkg::PH_CHECK_HI: begin
          check_hi = b;
          state = sfd_pkg::PH_CHECK_LO;
        end
        default: begin
          rx = {check_hi, b};
          r.kind = (rx == crc) ? sfd_pkg::KIND_CRC_OK : sfd_pkg::KIND_CRC_BAD;
          r.frame_type = type_word;
          r.frame_length = len_byte;
          r.received_check = rx;
          r.computed_check = crc;
          expected_q.push_back(r);
          state = sfd_pkg::PH_HUNT;
        end
      endcase
    endfunction

    function void compare_field(string name, logic [sfd_pkg::CRC_W-1:0] want,
                                logic [sfd_pkg::CRC_W-1:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %h, got %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(sfd_pkg::result_t got);
      sfd_pkg::result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result expected none, got kind %0d data %h", $time, got.kind,
                 got.data_byte);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("kind", 16'(want.kind), 16'(got.kind));
      compare_field("data_byte", 16'(want.data_byte), 16'(got.data_byte));
      compare_field("byte_index", 16'(want.byte_index), 16'(got.byte_index));
      compare_field("frame_type", want.frame_type, got.frame_type);
      compare_field("frame_length", 16'(want.frame_length), 16'(got.frame_length));
      compare_field("received_check", want.received_check, got.received_check);
      compare_field("computed_check", want.computed_check, got.computed_check);
    endfunction
  endclass

  frame_scoreboard sb = new();
  bit idle_in = 1'b0;
  bit idle_out = 1'b0;

  sync_frame_deframer_crc16 u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_data_byte      (out_data_byte),
    .out_byte_index     (out_byte_index),
    .out_frame_type     (out_frame_type),
    .out_frame_length   (out_frame_length),
    .out_received_check (out_received_check),
    .out_computed_check (out_computed_check),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always #6 clk = ~clk;

  initial begin
    #3_000_000;
    $display("sync_frame_deframer_crc16 regression: fail");
    $finish;
  end

  task automatic send_byte(input logic [sfd_pkg::BYTE_W-1:0] b);
    int gap;
    gap = idle_in ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_input(b);
  endtask

  // drop valid, let all results drain, then cover the parser/output pipeline
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(input logic [sfd_pkg::BYTE_W-1:0] first,
                            input logic [sfd_pkg::BYTE_W-1:0] second);
    cfg_we <= 1'b1;
    cfg_index <= sfd_pkg::CFG_SYNC_FIRST;
    cfg_wdata <= first;
    @(posedge clk);
    sb.write_reg(sfd_pkg::CFG_SYNC_FIRST, first);
    cfg_index <= sfd_pkg::CFG_SYNC_SECOND;
    cfg_wdata <= second;
    @(posedge clk);
    sb.write_reg(sfd_pkg::CFG_SYNC_SECOND, second);
    cfg_we <= 1'b0;
  endtask

  task automatic send_frame(input logic [sfd_pkg::BYTE_W-1:0] s1,
                            input logic [sfd_pkg::BYTE_W-1:0] s2,
                            input logic [sfd_pkg::CRC_W-1:0] kind_word, input int len,
                            input bit good, input bit regs_mid);
    logic [sfd_pkg::CRC_W-1:0] c;
    logic [sfd_pkg::CRC_W-1:0] rx;
    logic [sfd_pkg::BYTE_W-1:0] b;
    c = frame_scoreboard::crc_step(sfd_pkg::CRC_INIT, s1);
    send_byte(s1);
    c = frame_scoreboard::crc_step(c, s2);
    send_byte(s2);
    c = frame_scoreboard::crc_step(c, kind_word[15:8]);
    send_byte(kind_word[15:8]);
    c = frame_scoreboard::crc_step(c, kind_word[7:0]);
    send_byte(kind_word[7:0]);
    c = frame_scoreboard::crc_step(c, len[7:0]);
    send_byte(len[7:0]);
    // sync change while the frame is already past its sync bytes
    if (regs_mid) begin
      wait_drained();
      write_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      c = frame_scoreboard::crc_step(c, b);
      send_byte(b);
    end
    rx = good ? c : c ^ 16'($urandom_range(1, 65535));
    send_byte(rx[15:8]);
    send_byte(rx[7:0]);
  endtask

  initial begin : result_sink
    int stall;
    sfd_pkg::result_t got;
    wait (rst_n);
    forever begin
      stall = idle_out ? $urandom_range(0, 10) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.kind = sfd_pkg::kind_t'(out_kind);
      got.data_byte = out_data_byte;
      got.byte_index = out_byte_index;
      got.frame_type = out_frame_type;
      got.frame_length = out_frame_length;
      got.received_check = out_received_check;
      got.computed_check = out_computed_check;
      sb.check_result(got);
    end
  end

  initial begin : stimulus
    logic [sfd_pkg::BYTE_W-1:0] s1;
    logic [sfd_pkg::BYTE_W-1:0] s2;
    logic [sfd_pkg::BYTE_W-1:0] b;
    int done;
    int pick;
    int len;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_in = 1'b1;
    idle_out = 1'b1;

    // zero length, all-ones type, good check
    send_frame(sfd_pkg::SYNC_FIRST_RST, sfd_pkg::SYNC_SECOND_RST, 16'hFFFF, 0, 1'b1, 1'b0);
    // wrong second sync is consumed; the real second sync then falls into the hunt
    send_byte(sfd_pkg::SYNC_FIRST_RST);
    send_byte(sfd_pkg::SYNC_FIRST_RST);
    send_byte(sfd_pkg::SYNC_SECOND_RST);
    send_frame(sfd_pkg::SYNC_FIRST_RST, sfd_pkg::SYNC_SECOND_RST, 16'h0000, 1, 1'b0, 1'b0);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin s1 = 8'h00; s2 = 8'h00; end
        1: begin s1 = 8'hFF; s2 = 8'hFF; end
        2: begin s1 = 8'h00; s2 = 8'hFF; end
        3: begin s1 = 8'hFF; s2 = 8'h00; end
        7: begin s1 = sfd_pkg::SYNC_FIRST_RST; s2 = sfd_pkg::SYNC_SECOND_RST; end
        default: begin
          s1 = 8'($urandom_range(0, 255));
          s2 = 8'($urandom_range(0, 255));
        end
      endcase
      write_regs(s1, s2);
      if (ph == 1) begin
        idle_in = 1'b0;
        idle_out = 1'b0;
      end else begin
        idle_in = $urandom_range(0, 3) != 0;
        idle_out = $urandom_range(0, 3) != 0;
      end
      if (ph == 3) begin
        send_frame(sb.sync_first, sb.sync_second, 16'($urandom), 255, 1'b1, 1'b0);
      end
      if (ph == 5) begin
        send_frame(sb.sync_first, sb.sync_second, 16'($urandom), 3, 1'b1, 1'b1);
      end
      done = 0;
      while (done < 34) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          len = ($urandom_range(0, 6) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
          send_frame(sb.sync_first, sb.sync_second, 16'($urandom), len,
                     $urandom_range(0, 9) < 7, 1'b0);
          done += len + 7;
        end else if (pick < 80) begin
          send_byte(sb.sync_first);
          do b = 8'($urandom_range(0, 255)); while (b == sb.sync_second);
          send_byte(b);
          done += 2;
        end else if (pick < 88) begin
          // truncated header: later bytes land in the open frame
          send_byte(sb.sync_first);
          send_byte(sb.sync_second);
          len = $urandom_range(1, 3);
          repeat (len) send_byte(8'($urandom_range(0, 255)));
          done += len + 2;
        end else begin
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("sync_frame_deframer_crc16 regression: pass");
    end else begin
      $display("sync_frame_deframer_crc16 regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sfd_pkg.sv
rtl/sfd_parser.sv
rtl/sync_frame_deframer_crc16.sv
sim/tb_sync_frame_deframer_crc16.sv
